### src/pst_pkg.sv
// package for the peer session table: field widths, codes, reset values
// and the entry and result types used by the modules
// no dependencies
`timescale 1ns / 1ps

package pst_pkg;

    localparam int TABLE_ENTRIES_DEF = 16;

    localparam int KIND_W     = 2;
    localparam int ID_W       = 64;
    localparam int ADDR_W     = 48;
    localparam int POW_W      = 12;
    localparam int TIME_W     = 32;
    localparam int LID_W      = 16;
    localparam int MS_W       = 16;
    localparam int EV_W       = 3;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 64;

    // input kinds
    localparam logic [KIND_W-1:0] KIND_HEARTBEAT = 2'd0;
    localparam logic [KIND_W-1:0] KIND_DATA      = 2'd1;
    localparam logic [KIND_W-1:0] KIND_TICK      = 2'd2;
    localparam logic [KIND_W-1:0] KIND_SEND      = 2'd3;

    // result events
    localparam logic [EV_W-1:0] EV_ACK      = 3'd0;
    localparam logic [EV_W-1:0] EV_DETECTED = 3'd1;
    localparam logic [EV_W-1:0] EV_LOST     = 3'd2;
    localparam logic [EV_W-1:0] EV_FORWARD  = 3'd3;
    localparam logic [EV_W-1:0] EV_SEND_TO  = 3'd4;
    localparam logic [EV_W-1:0] EV_FULL     = 3'd5;

    // configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_OWN_ID    = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_MIN_POWER = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_TIMEOUT   = 2'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_PERIOD    = 2'd3;

    // reset values (threshold is -120.0 dBm in tenths)
    localparam logic [ID_W-1:0]         OWN_ID_RST    = '0;
    localparam logic signed [POW_W-1:0] MIN_POWER_RST = -12'sd1200;
    localparam logic [MS_W-1:0]         TIMEOUT_RST   = 16'd2000;
    localparam logic [MS_W-1:0]         PERIOD_RST    = 16'd1000;

    typedef struct packed {
        logic [ID_W-1:0]   peer_id;
        logic [LID_W-1:0]  local_id;
        logic [ADDR_W-1:0] address;
        logic [TIME_W-1:0] last_seen;
    } t_entry;

    typedef struct packed {
        logic [EV_W-1:0]          event_res;
        logic [LID_W-1:0]         local_id;
        logic [ID_W-1:0]          remote_id;
        logic [ADDR_W-1:0]        dest_address;
        logic signed [POW_W-1:0]  ack_power_tenths;
        logic                     last;
    } t_result;

endpackage

### src/pst_in_if.sv
// input channel of the peer session table: valid/ready and item fields
// depends on pst_pkg
`timescale 1ns / 1ps

interface pst_in_if import pst_pkg::*; ();
    logic                    valid;
    logic                    ready;
    logic [KIND_W-1:0]       kind;
    logic [ID_W-1:0]         peer_id;
    logic [ADDR_W-1:0]       peer_address;
    logic signed [POW_W-1:0] rx_power_tenths;
    logic [TIME_W-1:0]       now_ms;
    logic [LID_W-1:0]        target_local_id;

    modport source (
        output valid, kind, peer_id, peer_address, rx_power_tenths, now_ms,
               target_local_id,
        input  ready
    );
    modport sink (
        input  valid, kind, peer_id, peer_address, rx_power_tenths, now_ms,
               target_local_id,
        output ready
    );
endinterface

### src/pst_out_if.sv
// result channel of the peer session table: valid/ready and result fields
// depends on pst_pkg
`timescale 1ns / 1ps

interface pst_out_if import pst_pkg::*; ();
    logic                    valid;
    logic                    ready;
    logic [EV_W-1:0]         event_res;
    logic [LID_W-1:0]        local_id;
    logic [ID_W-1:0]         remote_id;
    logic [ADDR_W-1:0]       dest_address;
    logic signed [POW_W-1:0] ack_power_tenths;
    logic                    last;

    modport source (
        output valid, event_res, local_id, remote_id, dest_address,
               ack_power_tenths, last,
        input  ready
    );
    modport sink (
        input  valid, event_res, local_id, remote_id, dest_address,
               ack_power_tenths, last,
        output ready
    );
endinterface

### src/peer_session_table_with_aging.sv
// Peer session table with timeout aging. One item is taken at a time; ready
// is low while it is worked. The table sits in a memory with one read and
// one write port, and one sequencer walks it one entry per cycle, each read
// registered before the entry is compared. A heartbeat or data message is
// looked up over the whole table, then decided, then its results are sent
// (two for a new peer or a full table). A low-power heartbeat or a tick
// inside the sweep period is dropped without a walk. A sweep or send first
// marks entries in one pass, then finds each reported entry by a fresh
// minimum search over local ids. Results leave through an output register,
// so the sequencer keeps going while one waits.
// Depends on pst_pkg, pst_in_if, pst_out_if and pst_out_stage.
`timescale 1ns / 1ps

module peer_session_table_with_aging import pst_pkg::*; #(
    parameter int TABLE_ENTRIES = TABLE_ENTRIES_DEF
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    pst_in_if.sink                i_in,
    pst_out_if.source             o_out,
    input  logic                  i_cfg_we,
    input  logic [CFG_IDX_W-1:0]  i_cfg_idx,
    input  logic [CFG_DATA_W-1:0] i_cfg_data
);

    localparam int IDX_W = (TABLE_ENTRIES > 1) ? $clog2(TABLE_ENTRIES) : 1;
    localparam int CNT_W = $clog2(TABLE_ENTRIES + 1);
    localparam logic [CNT_W-1:0] CNT_END = CNT_W'(TABLE_ENTRIES);
    localparam logic [CNT_W-1:0] CNT_ONE = CNT_W'(1);

    typedef enum logic [3:0] {
        S_IDLE, S_SCAN, S_DECIDE, S_EMIT_A, S_EMIT_ACK, S_EMIT_FWD,
        S_PICK, S_MIN, S_FETCH, S_EMIT_ORD
    } t_state;

    t_state r_state;

    // configuration
    logic [ID_W-1:0]         r_own_id;
    logic signed [POW_W-1:0] r_min_pow;
    logic [MS_W-1:0]         r_timeout;
    logic [MS_W-1:0]         r_period;

    // current item
    logic [KIND_W-1:0]       r_kind;
    logic [ID_W-1:0]         r_pid;
    logic [ADDR_W-1:0]       r_addr;
    logic signed [POW_W-1:0] r_pow;
    logic [TIME_W-1:0]       r_now;
    logic [LID_W-1:0]        r_target;

    // walk over the table
    logic [CNT_W-1:0]  r_idx;
    logic              r_ev;
    logic [IDX_W-1:0]  r_ev_idx;
    logic              r_hit;
    logic [IDX_W-1:0]  r_hit_idx;
    logic [LID_W-1:0]  r_hit_lid;
    logic              r_free;
    logic [IDX_W-1:0]  r_free_idx;
    logic [LID_W-1:0]  r_ack_lid;
    logic              r_full;
    logic [CNT_W-1:0]  r_npick;
    logic              r_best_vld;
    logic [IDX_W-1:0]  r_best_idx;
    logic [LID_W-1:0]  r_best_lid;

    logic [TABLE_ENTRIES-1:0] r_valid;
    logic [TABLE_ENTRIES-1:0] r_pick;
    logic [LID_W-1:0]         r_next_lid;
    logic [TIME_W-1:0]        r_last_sweep;

    // table memory
    t_entry r_mem [TABLE_ENTRIES];
    t_entry r_rd;

    logic             w_scanning;
    logic             w_issue;
    logic             w_scan_done;
    logic [IDX_W-1:0] w_raddr;
    logic             w_we;
    logic [IDX_W-1:0] w_waddr;
    t_entry           w_wdata;
    logic             w_ev_valid;
    logic [TIME_W-1:0] w_age;
    logic             w_stale;
    logic [TIME_W-1:0] w_tick_gap;
    logic             w_pow_low;
    logic             w_sel;
    logic             w_accept;
    logic [LID_W-1:0] n_next_lid;
    logic             w_emit;
    logic             w_up_ready;
    t_result          w_res;

    assign i_in.ready = (r_state == S_IDLE);
    assign w_accept   = i_in.valid && (r_state == S_IDLE);

    assign w_scanning  = (r_state == S_SCAN) || (r_state == S_PICK) || (r_state == S_MIN);
    assign w_issue     = (r_idx != CNT_END);
    assign w_scan_done = !w_issue && !r_ev;
    assign w_raddr     = w_scanning ? r_idx[IDX_W-1:0] : r_best_idx;

    assign w_ev_valid = r_valid[r_ev_idx];
    assign w_age      = r_now - r_rd.last_seen;
    assign w_stale    = w_age > {{(TIME_W-MS_W){1'b0}}, r_timeout};
    assign w_tick_gap = i_in.now_ms - r_last_sweep;
    assign w_pow_low  = i_in.rx_power_tenths < r_min_pow;

    always_comb begin
        n_next_lid = r_next_lid + 1'b1;
        if (n_next_lid == '0) begin
            n_next_lid = LID_W'(1);
        end
    end

    // entry selection during the marking pass
    always_comb begin
        if (r_kind == KIND_TICK) begin
            w_sel = w_ev_valid && w_stale;
        end else begin
            w_sel = w_ev_valid && ((r_target == '0) || (r_rd.local_id == r_target));
        end
    end

    // heartbeat write-back: refresh a known entry or fill a free one
    always_comb begin
        w_we            = (r_state == S_DECIDE) && (r_kind == KIND_HEARTBEAT)
                          && (r_hit || r_free);
        w_waddr         = r_hit ? r_hit_idx : r_free_idx;
        w_wdata.peer_id   = r_pid;
        w_wdata.local_id  = r_hit ? r_hit_lid : n_next_lid;
        w_wdata.address   = r_addr;
        w_wdata.last_seen = r_now;
    end

    always_ff @(posedge i_clk) begin
        if (w_we) begin
            r_mem[w_waddr] <= w_wdata;
        end
        r_rd <= r_mem[w_raddr];
    end

    // result being offered to the output register
    always_comb begin
        w_emit                 = 1'b0;
        w_res.event_res        = EV_ACK;
        w_res.local_id         = r_ack_lid;
        w_res.remote_id        = r_pid;
        w_res.dest_address     = '0;
        w_res.ack_power_tenths = '0;
        w_res.last             = 1'b1;
        unique case (r_state)
            S_EMIT_A: begin
                w_emit             = 1'b1;
                w_res.event_res    = r_full ? EV_FULL : EV_DETECTED;
                w_res.dest_address = r_addr;
                w_res.last         = 1'b0;
            end
            S_EMIT_ACK: begin
                w_emit                 = 1'b1;
                w_res.event_res        = EV_ACK;
                w_res.remote_id        = r_own_id;
                w_res.dest_address     = r_addr;
                w_res.ack_power_tenths = r_pow;
            end
            S_EMIT_FWD: begin
                w_emit          = 1'b1;
                w_res.event_res = EV_FORWARD;
            end
            S_EMIT_ORD: begin
                w_emit          = 1'b1;
                w_res.event_res = (r_kind == KIND_TICK) ? EV_LOST : EV_SEND_TO;
                w_res.local_id  = r_rd.local_id;
                w_res.remote_id = r_rd.peer_id;
                w_res.dest_address = (r_kind == KIND_TICK) ? '0 : r_rd.address;
                w_res.last      = (r_npick == CNT_ONE);
            end
            default: begin
                w_emit = 1'b0;
            end
        endcase
    end

    pst_out_stage u_out (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_load     (w_emit),
        .i_res      (w_res),
        .o_ready_up (w_up_ready),
        .o_out      (o_out)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_own_id  <= OWN_ID_RST;
            r_min_pow <= MIN_POWER_RST;
            r_timeout <= TIMEOUT_RST;
            r_period  <= PERIOD_RST;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                CFG_OWN_ID:    r_own_id  <= i_cfg_data;
                CFG_MIN_POWER: r_min_pow <= i_cfg_data[POW_W-1:0];
                CFG_TIMEOUT:   r_timeout <= i_cfg_data[MS_W-1:0];
                CFG_PERIOD:    r_period  <= i_cfg_data[MS_W-1:0];
            endcase
        end
    end

    // item payload
    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_kind   <= i_in.kind;
            r_pid    <= i_in.peer_id;
            r_addr   <= i_in.peer_address;
            r_pow    <= i_in.rx_power_tenths;
            r_now    <= i_in.now_ms;
            r_target <= i_in.target_local_id;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= S_IDLE;
            r_idx        <= '0;
            r_ev         <= 1'b0;
            r_ev_idx     <= '0;
            r_hit        <= 1'b0;
            r_hit_idx    <= '0;
            r_hit_lid    <= '0;
            r_free       <= 1'b0;
            r_free_idx   <= '0;
            r_ack_lid    <= '0;
            r_full       <= 1'b0;
            r_npick      <= '0;
            r_best_vld   <= 1'b0;
            r_best_idx   <= '0;
            r_best_lid   <= '0;
            r_valid      <= '0;
            r_pick       <= '0;
            r_next_lid   <= '0;
            r_last_sweep <= '0;
        end else begin
            // read issue, and evaluation in the cycle after
            if (w_scanning) begin
                if (w_issue) begin
                    r_idx <= r_idx + 1'b1;
                end
                r_ev     <= w_issue;
                r_ev_idx <= r_idx[IDX_W-1:0];
            end

            unique case (r_state)
                S_IDLE: begin
                    if (w_accept) begin
                        r_idx      <= '0;
                        r_ev       <= 1'b0;
                        r_hit      <= 1'b0;
                        r_free     <= 1'b0;
                        r_npick    <= '0;
                        r_best_vld <= 1'b0;
                        unique case (i_in.kind)
                            KIND_HEARTBEAT: r_state <= w_pow_low ? S_IDLE : S_SCAN;
                            KIND_DATA:      r_state <= S_SCAN;
                            KIND_TICK: begin
                                if (w_tick_gap > {{(TIME_W-MS_W){1'b0}}, r_period}) begin
                                    r_last_sweep <= i_in.now_ms;
                                    r_state      <= S_PICK;
                                end
                            end
                            KIND_SEND:      r_state <= S_PICK;
                        endcase
                    end
                end
                S_SCAN: begin
                    if (r_ev) begin
                        if (w_ev_valid && (r_rd.peer_id == r_pid) && !r_hit) begin
                            r_hit     <= 1'b1;
                            r_hit_idx <= r_ev_idx;
                            r_hit_lid <= r_rd.local_id;
                        end
                        if (!w_ev_valid && !r_free) begin
                            r_free     <= 1'b1;
                            r_free_idx <= r_ev_idx;
                        end
                    end
                    if (w_scan_done) begin
                        r_state <= S_DECIDE;
                    end
                end
                S_DECIDE: begin
                    if (r_kind == KIND_HEARTBEAT) begin
                        if (r_hit) begin
                            r_ack_lid <= r_hit_lid;
                            r_full    <= 1'b0;
                            r_state   <= S_EMIT_ACK;
                        end else if (r_free) begin
                            r_next_lid          <= n_next_lid;
                            r_valid[r_free_idx] <= 1'b1;
                            r_ack_lid           <= n_next_lid;
                            r_full              <= 1'b0;
                            r_state             <= S_EMIT_A;
                        end else begin
                            r_ack_lid <= '0;
                            r_full    <= 1'b1;
                            r_state   <= S_EMIT_A;
                        end
                    end else if (r_hit) begin
                        r_ack_lid <= r_hit_lid;
                        r_state   <= S_EMIT_FWD;
                    end else begin
                        r_state <= S_IDLE;
                    end
                end
                S_EMIT_A: begin
                    if (w_up_ready) begin
                        r_state <= S_EMIT_ACK;
                    end
                end
                S_EMIT_ACK, S_EMIT_FWD: begin
                    if (w_up_ready) begin
                        r_state <= S_IDLE;
                    end
                end
                S_PICK: begin
                    if (r_ev) begin
                        r_pick[r_ev_idx] <= w_sel;
                        if (w_sel) begin
                            r_npick <= r_npick + 1'b1;
                            if (r_kind == KIND_TICK) begin
                                r_valid[r_ev_idx] <= 1'b0;
                            end
                        end
                    end
                    if (w_scan_done) begin
                        if (r_npick == '0) begin
                            r_state <= S_IDLE;
                        end else begin
                            r_idx      <= '0;
                            r_best_vld <= 1'b0;
                            r_state    <= S_MIN;
                        end
                    end
                end
                S_MIN: begin
                    // lowest local id wins, earlier index on a tie
                    if (r_ev && r_pick[r_ev_idx]
                        && (!r_best_vld || (r_rd.local_id < r_best_lid))) begin
                        r_best_vld <= 1'b1;
                        r_best_idx <= r_ev_idx;
                        r_best_lid <= r_rd.local_id;
                    end
                    if (w_scan_done) begin
                        r_state <= S_FETCH;
                    end
                end
                S_FETCH: begin
                    r_state <= S_EMIT_ORD;
                end
                S_EMIT_ORD: begin
                    if (w_up_ready) begin
                        r_pick[r_best_idx] <= 1'b0;
                        r_npick            <= r_npick - 1'b1;
                        if (r_npick == CNT_ONE) begin
                            r_state <= S_IDLE;
                        end else begin
                            r_idx      <= '0;
                            r_ev       <= 1'b0;
                            r_best_vld <= 1'b0;
                            r_state    <= S_MIN;
                        end
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

endmodule

### src/pst_out_stage.sv
// output register of the peer session table: holds one result transaction
// depends on pst_pkg and pst_out_if
`timescale 1ns / 1ps

module pst_out_stage import pst_pkg::*; (
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      i_load,
    input  t_result   i_res,
    output logic      o_ready_up,
    pst_out_if.source o_out
);

    logic    r_valid;
    t_result r_res;

    assign o_ready_up = !r_valid || o_out.ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_load && o_ready_up) begin
            r_valid <= 1'b1;
        end else if (o_out.ready) begin
            r_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_load && o_ready_up) begin
            r_res <= i_res;
        end
    end

    assign o_out.valid            = r_valid;
    assign o_out.event_res        = r_res.event_res;
    assign o_out.local_id         = r_res.local_id;
    assign o_out.remote_id        = r_res.remote_id;
    assign o_out.dest_address     = r_res.dest_address;
    assign o_out.ack_power_tenths = r_res.ack_power_tenths;
    assign o_out.last             = r_res.last;

endmodule
